// ===== rtl/self_organizing_list_search_defines.svh =====
// Assertion macros for the self-organising search table.
// Included by self_organizing_list_search, which carries concurrent checks; no other dependencies.
`ifndef SELF_ORGANIZING_LIST_SEARCH_DEFINES_SVH
`define SELF_ORGANIZING_LIST_SEARCH_DEFINES_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge out of reset
`define SOLS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sols check failed");
// Check that a condition never holds out of reset
`define SOLS_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("sols forbidden condition seen");
`else
`define SOLS_ASSERT(label, clk, rst_n, prop)
`define SOLS_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/sols_pkg.sv =====
// Shared types and constants for the self-organising search table.
// Used by sols_cell and self_organizing_list_search; no dependencies.
package sols_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int POS_W       = 6;
  localparam int KEY_W       = 32;
  localparam int CFG_W       = 7;

  // Request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // Reorder mode codes; the unused code acts as plain search
  localparam logic [1:0] MODE_PLAIN     = 2'd0;
  localparam logic [1:0] MODE_MTF       = 2'd1;
  localparam logic [1:0] MODE_TRANSPOSE = 2'd2;
  localparam logic [1:0] MODE_UNUSED    = 2'd3;

  // Configuration register indexes
  localparam logic REG_REORDER_MODE   = 1'b0;
  localparam logic REG_ENTRIES_IN_USE = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [5:0]              entry_index;
    logic signed [KEY_W-1:0] key_value;
  } sols_in_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } sols_out_t;

  // Per-cell update controls
  typedef struct packed {
    logic we;          // take the common write data
    logic take_left;   // take the left neighbour's key
    logic take_right;  // take the right neighbour's key
  } sols_cell_ctrl_t;

endpackage

// ===== rtl/sols_cell.sv =====
// One table cell: holds a key, compares it with the search key and
// takes a new key from the write bus or a neighbour. Depends on sols_pkg.
module sols_cell import sols_pkg::*; (
  input  logic                    clk_i,
  input  sols_cell_ctrl_t         ctrl_i,
  input  logic signed [KEY_W-1:0] wdata_i,
  input  logic signed [KEY_W-1:0] left_i,
  input  logic signed [KEY_W-1:0] right_i,
  input  logic signed [KEY_W-1:0] search_key_i,
  output logic signed [KEY_W-1:0] key_o,
  output logic                    match_o
);

  logic signed [KEY_W-1:0] key_q, key_d;
  logic                    match_q;

  // Select the next key: write bus first, then neighbours
  always_comb begin
    key_d = key_q;
    if (ctrl_i.we) begin
      key_d = wdata_i;
    end else if (ctrl_i.take_left) begin
      key_d = left_i;
    end else if (ctrl_i.take_right) begin
      key_d = right_i;
    end
  end

  // Hold the key and register the compare
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    match_q <= (key_q == search_key_i);
  end

  assign key_o   = key_q;
  assign match_o = match_q;

endmodule

// ===== rtl/self_organizing_list_search.sv =====
// Self-organising search table: a row of key cells with parallel compare.
// Timing: an input transfer steps the sequencer through compare, priority
// encode and update; the result is registered in update, which waits while
// the output register is stalled. No new input is taken until idle again.
// Reset: clears control state and config (plain search, 0 entries in use);
// the key cells are not reset and hold no valid data until loaded.
`include "self_organizing_list_search_defines.svh"
module self_organizing_list_search import sols_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sols_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sols_out_t        out_data_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_ENC  = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [1:0]              mode_q;
  logic [CFG_W-1:0]        entries_q;
  logic                    req_q;
  logic [5:0]              idx_q;
  logic signed [KEY_W-1:0] sk_q;
  logic                    hit_q, hit_d;
  logic [IDX_W-1:0]        pos_q, pos_d;
  logic                    out_valid_q;
  sols_out_t               out_q;

  logic                    in_xfer;
  logic                    out_free;
  logic                    upd_go;
  logic                    reorder;
  logic signed [KEY_W-1:0] wdata;
  logic signed [KEY_W-1:0] keys  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]  match;
  logic [TABLE_DEPTH-1:0]  in_range;
  sols_cell_ctrl_t         ctrl  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]  we_vec, tl_vec, tr_vec;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign upd_go     = (state_q == S_UPD) && out_free;
  assign reorder    = upd_go && (req_q == REQ_SEARCH) && hit_q && (pos_q != '0);
  assign wdata      = (state_q == S_IDLE) ? in_data_i.key_value : sk_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_PLAIN;
      entries_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_REORDER_MODE:   mode_q    <= cfg_wdata_i[1:0];
        REG_ENTRIES_IN_USE: entries_q <= cfg_wdata_i;
        default:            mode_q    <= mode_q;
      endcase
    end
  end

  // Sequencer: compare, encode, update
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_xfer) state_d = S_CMP;
      S_CMP:   state_d = S_ENC;
      S_ENC:   state_d = S_UPD;
      S_UPD:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q <= in_data_i.req_type;
      idx_q <= in_data_i.entry_index;
      sk_q  <= in_data_i.key_value;
    end
  end

  // Find the first matching cell inside the scan window
  always_comb begin
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      in_range[j] = (32'(entries_q) > j);
    end
  end

  always_comb begin
    hit_d = |(match & in_range);
    pos_d = '0;
    for (int j = TABLE_DEPTH - 1; j >= 0; j--) begin
      if (match[j] && in_range[j]) pos_d = IDX_W'(j);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_ENC) begin
      hit_q <= hit_d;
      pos_q <= pos_d;
    end
  end

  // Drive the cell controls for loads and reordering
  always_comb begin
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      ctrl[j] = '0;
      if (in_xfer && (in_data_i.req_type == REQ_LOAD) &&
          (32'(in_data_i.entry_index) == j)) begin
        ctrl[j].we = 1'b1;
      end
      if (reorder && (mode_q == MODE_MTF)) begin
        if (j == 0) ctrl[j].we = 1'b1;
        else if (j <= int'(pos_q)) ctrl[j].take_left = 1'b1;
      end
      if (reorder && (mode_q == MODE_TRANSPOSE)) begin
        if (j == int'(pos_q)) ctrl[j].take_left = 1'b1;
        if (j == int'(pos_q) - 1) ctrl[j].take_right = 1'b1;
      end
      we_vec[j] = ctrl[j].we;
      tl_vec[j] = ctrl[j].take_left;
      tr_vec[j] = ctrl[j].take_right;
    end
  end

  // Row of cells, each wired to its neighbours
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic signed [KEY_W-1:0] left_key, right_key;
    if (g == 0) begin : g_first
      assign left_key = keys[g];
    end else begin : g_left
      assign left_key = keys[g-1];
    end
    if (g == TABLE_DEPTH - 1) begin : g_last
      assign right_key = keys[g];
    end else begin : g_right
      assign right_key = keys[g+1];
    end
    sols_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl[g]),
      .wdata_i      (wdata),
      .left_i       (left_key),
      .right_i      (right_key),
      .search_key_i (sk_q),
      .key_o        (keys[g]),
      .match_o      (match[g])
    );
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_go) begin
      if (req_q == REQ_LOAD) begin
        out_q.found    <= 1'b0;
        out_q.position <= idx_q;
      end else begin
        out_q.found    <= hit_q;
        out_q.position <= hit_q ? POS_W'(pos_q) : '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `SOLS_ASSERT(a_one_at_a_time, clk_i, rst_ni, in_xfer |=> !in_ready_o)
  `SOLS_ASSERT(a_single_writer, clk_i, rst_ni, $onehot0(we_vec))
  `SOLS_ASSERT(a_update_emits, clk_i, rst_ni, upd_go |=> out_valid_q && state_q == S_IDLE)
  `SOLS_NEVER(a_no_double_take, clk_i, rst_ni, |(tl_vec & tr_vec))

endmodule
